>>> design/mbq_pkg.sv
// ----------------------------------------------------------------------------
// mbq_pkg: shared types and constants for the cascaded biquad low-pass filter
// Formats, opcodes, coefficient slots, controller states and the command
// struct that joins the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package mbq_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int SECTIONS_DEF = 4;
    localparam int FIELDS_OUT   = 8;

    localparam int SAMPLE_W = 24;
    localparam int OUT_W    = 16;
    localparam int SIG_W    = 48;
    localparam int COEF_W   = 32;
    localparam int NCOEF    = 5;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef enum logic [2:0] {
        SLOT_B0 = 3'd0,
        SLOT_B1 = 3'd1,
        SLOT_B2 = 3'd2,
        SLOT_A1 = 3'd3,
        SLOT_A2 = 3'd4
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,   // fetch history and coefficients for one section
        ST_MAC,    // five product terms, one per cycle
        ST_SAT,    // saturate, write back history
        ST_DONE    // finished word waits for the output register
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       start;     // latch record, clear channel/section
        logic       load;      // read history for current ch/section
        logic       mac;       // accumulate one term
        logic [2:0] term;      // which term
        logic       wb;        // saturate and write back
        logic       push;      // copy finished word into output register
    } t_cmd;

    localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

endpackage
`default_nettype wire

>>> design/mbq_datapath.sv
// ----------------------------------------------------------------------------
// mbq_datapath: history memories, coefficient store and one shared MAC
// One product term per cycle: 48x32 product split into two 24x32 halves.
// ----------------------------------------------------------------------------
`default_nettype none
module mbq_datapath #(
    parameter int CHANNELS = mbq_pkg::CHANNELS_DEF,
    parameter int SECTIONS = mbq_pkg::SECTIONS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mbq_pkg::t_cmd                i_cmd,
    input  wire logic [$clog2(CHANNELS+1)-1:0] i_ch,
    input  wire logic [$clog2(SECTIONS+1)-1:0] i_sec,
    input  wire logic [mbq_pkg::FIELDS_OUT*mbq_pkg::SAMPLE_W-1:0] i_samples,
    input  wire logic                         i_cwr,
    input  wire logic [3:0]                   i_csec,
    input  wire logic [2:0]                   i_cslot,
    input  wire logic signed [mbq_pkg::COEF_W-1:0] i_cval,
    output logic [mbq_pkg::FIELDS_OUT*mbq_pkg::OUT_W-1:0] o_result
);
    localparam int SIG_W = mbq_pkg::SIG_W;
    localparam int COEF_W = mbq_pkg::COEF_W;
    localparam int OUT_W = mbq_pkg::OUT_W;
    localparam int NROW = CHANNELS * SECTIONS;
    localparam int RW = (NROW > 1) ? $clog2(NROW) : 1;
    localparam int CHW = $clog2(CHANNELS+1);
    localparam int SCW = $clog2(SECTIONS+1);
    localparam logic signed [SIG_W+8:0] ACC_MAX = (SIG_W+9)'(mbq_pkg::SIG_MAX);
    localparam logic signed [SIG_W+8:0] ACC_MIN = (SIG_W+9)'(mbq_pkg::SIG_MIN);

    // history row: x1,x2,y1,y2 per channel/section; valid bits model reset
    logic [4*SIG_W-1:0] r_hist [NROW];
    logic [NROW-1:0]    r_hvalid;
    logic signed [COEF_W-1:0] r_coef [SECTIONS*mbq_pkg::NCOEF];

    logic [RW-1:0] row;
    assign row = RW'((32'(i_ch[CHW-1:0]) * SECTIONS) + 32'(i_sec[SCW-1:0]));

    logic signed [SIG_W-1:0] r_x;
    logic signed [COEF_W-1:0] r_k [mbq_pkg::NCOEF];
    logic r_hv;
    logic [4*SIG_W-1:0] r_row;
    logic signed [SIG_W+8:0] r_acc_w;

    // coefficient writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SECTIONS*mbq_pkg::NCOEF; i++) r_coef[i] <= '0;
        end else if (i_cwr && 32'(i_csec) < SECTIONS && i_cslot <= mbq_pkg::SLOT_A2) begin
            r_coef[32'(i_csec)*mbq_pkg::NCOEF + 32'(i_cslot)] <= i_cval;
        end
    end

    // history memory read/write, registered read
    logic [4*SIG_W-1:0] n_wrow;
    logic signed [SIG_W-1:0] sat_y;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row <= r_hist[row];
        end
        if (i_cmd.wb) begin
            r_hist[row] <= n_wrow;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
        end else if (i_cmd.wb) begin
            r_hvalid[row] <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hv <= r_hvalid[row];
            for (int t = 0; t < mbq_pkg::NCOEF; t++)
                r_k[t] <= r_coef[32'(i_sec[SCW-1:0])*mbq_pkg::NCOEF + t];
        end
    end

    logic signed [SIG_W-1:0] h_x1, h_x2, h_y1, h_y2;
    assign h_x1 = r_hv ? r_row[SIG_W-1:0]         : '0;
    assign h_x2 = r_hv ? r_row[2*SIG_W-1:SIG_W]   : '0;
    assign h_y1 = r_hv ? r_row[3*SIG_W-1:2*SIG_W] : '0;
    assign h_y2 = r_hv ? r_row[4*SIG_W-1:3*SIG_W] : '0;

    // operand select
    logic signed [SIG_W-1:0] op_s;
    logic signed [COEF_W-1:0] op_c;
    always_comb begin
        case (i_cmd.term)
            3'd0:    op_s = r_x;
            3'd1:    op_s = h_x1;
            3'd2:    op_s = h_x2;
            3'd3:    op_s = h_y1;
            default: op_s = h_y2;
        endcase
        op_c = r_k[(i_cmd.term > 3'd4) ? 3'd4 : i_cmd.term];
    end

    // split product: hi(24s)*c and lo(24u)*c
    logic signed [SIG_W+COEF_W+1:0] p_hi, p_lo, p_sum;
    logic signed [SIG_W+COEF_W+1:0] term;
    assign p_hi = (SIG_W+COEF_W+2)'($signed(op_s[SIG_W-1:24]) * op_c);
    assign p_lo = (SIG_W+COEF_W+2)'($signed({1'b0, op_s[23:0]}) * op_c)
                + (SIG_W+COEF_W+2)'(64'sd1 <<< 27);
    assign p_sum = p_hi + (p_lo >>> 24);
    assign term = p_sum >>> 4;

    logic signed [SIG_W+COEF_W+1:0] acc_ext, n_acc;
    assign acc_ext = (SIG_W+COEF_W+2)'(r_acc_w);
    always_comb begin
        n_acc = (i_cmd.term >= 3'd3) ? acc_ext - term : acc_ext + term;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_acc_w <= '0;
        else if (i_cmd.mac) r_acc_w <= (SIG_W+9)'(n_acc);
    end

    always_comb begin
        if (r_acc_w > ACC_MAX) sat_y = mbq_pkg::SIG_MAX;
        else if (r_acc_w < ACC_MIN) sat_y = mbq_pkg::SIG_MIN;
        else sat_y = SIG_W'(r_acc_w);
        n_wrow = {h_y1, sat_y, h_x1, r_x};
    end

    // record latch and per-channel output
    logic [mbq_pkg::FIELDS_OUT*mbq_pkg::SAMPLE_W-1:0] r_smp;
    logic [mbq_pkg::FIELDS_OUT*OUT_W-1:0] r_res;
    logic signed [SIG_W-1:0] in_x;
    logic signed [OUT_W-1:0] in16;
    logic [$clog2(mbq_pkg::FIELDS_OUT)-1:0] chs;
    assign chs = $clog2(mbq_pkg::FIELDS_OUT)'(i_ch);
    assign in16 = r_smp[32'(chs)*mbq_pkg::SAMPLE_W + 8 +: OUT_W];
    assign in_x = {{(SIG_W-32){in16[OUT_W-1]}}, in16, 16'h0};

    logic signed [SIG_W-1:0] mag;
    logic signed [SIG_W-1:0] q;
    logic signed [OUT_W-1:0] fin;
    always_comb begin
        mag = sat_y[SIG_W-1] ? -sat_y : sat_y;
        q = sat_y[SIG_W-1] ? -(mag >>> 16) : (sat_y >>> 16);
        if (sat_y == mbq_pkg::SIG_MIN) q = -(SIG_W'(48'sh8000_0000));
        if (q > 48'sd32767) fin = 16'sh7fff;
        else if (q < -48'sd32768) fin = 16'sh8000;
        else fin = OUT_W'(q);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_smp <= i_samples;
            r_res <= '0;
        end else if (i_cmd.wb && 32'(i_sec) == SECTIONS-1) begin
            r_res[32'(chs)*OUT_W +: OUT_W] <= fin;
        end
        // output register frees the MAC while a word waits
        if (i_cmd.push) o_result <= r_res;
        if (i_cmd.load && i_sec == '0) r_x <= in_x;
        else if (i_cmd.wb) r_x <= sat_y;
    end

endmodule
`default_nettype wire

>>> design/mbq_ctrl.sv
// ----------------------------------------------------------------------------
// mbq_ctrl: sequencer for channels, sections and product terms
// Walks channel x section x five terms, then hands the word to the output.
// ----------------------------------------------------------------------------
`default_nettype none
module mbq_ctrl #(
    parameter int CHANNELS = mbq_pkg::CHANNELS_DEF,
    parameter int SECTIONS = mbq_pkg::SECTIONS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_out_taken,
    output mbq_pkg::t_cmd                     o_cmd,
    output logic [$clog2(CHANNELS+1)-1:0]     o_ch,
    output logic [$clog2(SECTIONS+1)-1:0]     o_sec,
    output logic                              o_idle,
    output logic                              o_out_valid
);
    mbq_pkg::t_state r_state, n_state;
    logic [$clog2(CHANNELS+1)-1:0] r_ch, n_ch;
    logic [$clog2(SECTIONS+1)-1:0] r_sec, n_sec;
    logic [2:0] r_term, n_term;
    logic r_full, n_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbq_pkg::ST_IDLE;
            r_ch <= '0; r_sec <= '0; r_term <= '0;
            r_full <= 1'b0;
        end else begin
            r_state <= n_state; r_ch <= n_ch; r_sec <= n_sec; r_term <= n_term;
            r_full <= n_full;
        end
    end

    always_comb begin
        n_state = r_state; n_ch = r_ch; n_sec = r_sec; n_term = r_term;
        o_cmd = '0;
        o_cmd.term = r_term;
        case (r_state)
            mbq_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    n_ch = '0; n_sec = '0;
                    n_state = mbq_pkg::ST_LOAD;
                end
            end
            mbq_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_term = '0;
                n_state = mbq_pkg::ST_MAC;
            end
            mbq_pkg::ST_MAC: begin
                o_cmd.mac = 1'b1;
                n_term = r_term + 3'd1;
                if (r_term == 3'd4) n_state = mbq_pkg::ST_SAT;
            end
            mbq_pkg::ST_SAT: begin
                o_cmd.wb = 1'b1;
                n_state = mbq_pkg::ST_LOAD;
                if (32'(r_sec) == SECTIONS-1) begin
                    n_sec = '0;
                    if (32'(r_ch) == CHANNELS-1) n_state = mbq_pkg::ST_DONE;
                    else n_ch = r_ch + 1'b1;
                end else begin
                    n_sec = r_sec + 1'b1;
                end
            end
            mbq_pkg::ST_DONE: begin
                // move the word out once the output register is free
                if (!r_full || i_out_taken) begin
                    o_cmd.push = 1'b1;
                    n_state = mbq_pkg::ST_IDLE;
                end
            end
            default: n_state = mbq_pkg::ST_IDLE;
        endcase
        n_full = (r_full && !i_out_taken) || o_cmd.push;
    end

    assign o_ch = r_ch;
    assign o_sec = r_sec;
    assign o_idle = (r_state == mbq_pkg::ST_IDLE);
    assign o_out_valid = r_full;

`ifndef SYNTHESIS
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbq_pkg::ST_MAC |-> r_term <= 3'd4) else $error("term range");
    a_load_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbq_pkg::ST_LOAD |=> r_state == mbq_pkg::ST_MAC) else $error("load seq");
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ch) < CHANNELS) else $error("ch range");
`endif
endmodule
`default_nettype wire

>>> design/multichannel_biquad_cascade_lpf.sv
// Each record passes through every section of every channel to give one output word:
//   each section of each channel takes a history load, five MAC terms, a write back.
// One shared MAC serves them all; a new record is taken only while the controller is
// idle. A held output word stalls the input only once the next record has finished.
// Coefficient words are stored while idle and give no output word. Reset (synchronous,
//   active low) clears state, coefficients and history valid bits.
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade_lpf: cascaded DF-I biquad low-pass, 8 channels
// Stream in, stream out; controller + shared-MAC datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module multichannel_biquad_cascade_lpf #(
    parameter int CHANNELS = mbq_pkg::CHANNELS_DEF,
    parameter int SECTIONS = mbq_pkg::SECTIONS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: sample_ch0..7 (24 each), coef_section(4), coef_slot(3), coef_value(32)
    input  wire logic [239:0] s_axis_tdata,
    // tuser: opcode
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: filtered_ch0..7 (16 each)
    output logic [127:0]      m_axis_tdata
);
    mbq_pkg::t_cmd cmd;
    logic [$clog2(CHANNELS+1)-1:0] ch;
    logic [$clog2(SECTIONS+1)-1:0] sec;
    logic idle, out_valid, acc;

    assign s_axis_tready = idle;
    assign acc = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid;

    mbq_ctrl #(.CHANNELS(CHANNELS), .SECTIONS(SECTIONS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_start(acc && s_axis_tuser == mbq_pkg::OP_FILTER),
        .i_out_taken(m_axis_tvalid && m_axis_tready),
        .o_cmd(cmd), .o_ch(ch), .o_sec(sec), .o_idle(idle), .o_out_valid(out_valid)
    );

    mbq_datapath #(.CHANNELS(CHANNELS), .SECTIONS(SECTIONS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_ch(ch), .i_sec(sec),
        .i_samples(s_axis_tdata[191:0]),
        .i_cwr(acc && s_axis_tuser == mbq_pkg::OP_COEF),
        .i_csec(s_axis_tdata[195:192]), .i_cslot(s_axis_tdata[198:196]),
        .i_cval(s_axis_tdata[230:199]),
        .o_result(m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_coef_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tuser == mbq_pkg::OP_COEF |=> s_axis_tready) else $error("coef word");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tuser == mbq_pkg::OP_FILTER |=> !s_axis_tready) else $error("start");
`endif
endmodule
`default_nettype wire
